// ===== src/bpaf_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
package bpaf_pkg;

  localparam int MAP_BITS_DEF = 32;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE = 1'b1;

  localparam logic [2:0] KIND_MARK  = 3'd0;
  localparam logic [2:0] KIND_CLEAR = 3'd1;
  localparam logic [2:0] KIND_TEST  = 3'd2;
  localparam logic [2:0] KIND_FIND  = 3'd3;
  localparam logic [2:0] KIND_RUN   = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic       last;
    logic [1:0] status;
    logic [4:0] position;
    logic       bit_set;
    logic [5:0] free_count;
  } scan_res_t;

endpackage

// ===== src/bitmap_page_allocator_fit_top.sv =====
// Top level of the bitmap page allocator: request control, configuration registers, scan unit.
// After start is taken, the scan unit rotates the whole map, then done strobes the result.
// One transaction at a time: busy stays high through the scan and the done cycle, as the bitmap
//   rotates past a single-bit scan point, one bit per cycle.
// Reset (rst, synchronous, active high): all bits clear, map_size 32, fit_mode first fit.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
module bitmap_page_allocator_fit_top #(
  parameter int MAP_BITS = bpaf_pkg::MAP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           kind,
  input  logic [4:0]                           bit_index,
  input  logic [5:0]                           request_size,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [4:0]                           position,
  output logic                                 bit_set,
  output logic [5:0]                           free_count,
  input  logic                                 cfg_we,
  input  logic [bpaf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bpaf_pkg::state_t     state;
  bpaf_pkg::state_t     state_next;
  bpaf_pkg::scan_ctrl_t ctrl;
  bpaf_pkg::scan_res_t  res;

  // Configuration registers; write them only while no transaction is in flight (the block does not enforce it).
  logic [5:0] map_size;
  logic [1:0] fit_mode;

  // Request held for the length of the scan.
  logic [2:0] kind_q;
  logic [4:0] bit_index_q;
  logic [5:0] request_size_q;

  logic accept;

  assign accept = start && (state == bpaf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= 6'd32;
      fit_mode <= bpaf_pkg::MODE_FIRST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpaf_pkg::REG_MAP_SIZE: map_size <= cfg_data[5:0];
        bpaf_pkg::REG_FIT_MODE: fit_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Latch the request fields on acceptance; they stay put until the next one.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q         <= kind;
      bit_index_q    <= bit_index;
      request_size_q <= request_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: idle -> scan until the last bit -> result (done) -> idle.
  always_comb begin
    state_next = state;
    case (state)
      bpaf_pkg::ST_IDLE: begin
        if (start) state_next = bpaf_pkg::ST_SCAN;
      end
      bpaf_pkg::ST_SCAN: begin
        if (res.last) state_next = bpaf_pkg::ST_DONE;
      end
      bpaf_pkg::ST_DONE: state_next = bpaf_pkg::ST_IDLE;
      default: state_next = bpaf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    ctrl.init = 1'b0;
    ctrl.step = 1'b0;
    case (state)
      bpaf_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.init = start;
      end
      bpaf_pkg::ST_SCAN: ctrl.step = 1'b1;
      bpaf_pkg::ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // The scan unit rotates the whole map once per transaction, applying the
  // update at the scan point and gathering counts and run data as it goes.
  bpaf_scan #(
    .MAP_BITS(MAP_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .kind        (kind_q),
    .bit_index   (bit_index_q),
    .request_size(request_size_q),
    .map_size    (map_size),
    .fit_mode    (fit_mode),
    .res         (res)
  );

  // Result fields are steady through the done cycle: the map has stopped rotating.
  assign status     = res.status;
  assign position   = res.position;
  assign bit_set    = res.bit_set;
  assign free_count = res.free_count;

endmodule

// ===== src/bpaf_scan.sv =====
// Rotating bitmap with one-bit-per-cycle scan for mark, clear, test, find and run search.
module bpaf_scan #(
  parameter int MAP_BITS = bpaf_pkg::MAP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpaf_pkg::scan_ctrl_t ctrl,
  input  logic [2:0]           kind,
  input  logic [4:0]           bit_index,
  input  logic [5:0]           request_size,
  input  logic [5:0]           map_size,
  input  logic [1:0]           fit_mode,
  output bpaf_pkg::scan_res_t  res
);

  localparam int IDXW  = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
  localparam int SIZEW = $clog2(MAP_BITS + 1);
  localparam int LW    = (SIZEW > 6) ? SIZEW : 6;

  logic [MAP_BITS-1:0] shreg;
  logic [IDXW-1:0]     cnt;
  logic [5:0]          cur_len;
  logic [IDXW-1:0]     cur_start;
  logic                found;
  logic [IDXW-1:0]     best_start;
  logic [5:0]          best_len;
  logic [5:0]          free_cnt;
  logic                alloc_hit;
  logic [IDXW-1:0]     alloc_pos;
  logic                test_bit;

  logic [LW-1:0]   n_act;
  logic [LW-1:0]   pos_ext;
  logic            active;
  logic            last_active;
  logic            idx_ok;
  logic            idx_here;
  logic            cur;
  logic            bit_new;
  logic            cand_valid;
  logic [IDXW-1:0] cand_start;
  logic [5:0]      cand_len;
  logic            take;

  // clamp the map size into 1..MAP_BITS
  always_comb begin
    if (map_size == 6'd0) begin
      n_act = LW'(1);
    end else if (LW'(map_size) > LW'(MAP_BITS)) begin
      n_act = LW'(MAP_BITS);
    end else begin
      n_act = LW'(map_size);
    end
  end

  assign pos_ext     = LW'(cnt);
  assign active      = pos_ext < n_act;
  assign last_active = pos_ext == (n_act - LW'(1));
  assign idx_ok      = LW'(bit_index) < n_act;
  assign idx_here    = idx_ok && (pos_ext == LW'(bit_index));
  assign cur         = shreg[0];

  always_comb begin
    bit_new = cur;
    case (kind)
      bpaf_pkg::KIND_MARK: begin
        if (idx_here) bit_new = 1'b1;
      end
      bpaf_pkg::KIND_CLEAR: begin
        if (idx_here) bit_new = 1'b0;
      end
      bpaf_pkg::KIND_FIND: begin
        if (active && !cur && !alloc_hit) bit_new = 1'b1;
      end
      default: bit_new = cur;
    endcase
  end

  // a run closes on the first used bit after it or at the last bit of the active map
  always_comb begin
    cand_valid = 1'b0;
    cand_start = cur_start;
    cand_len   = cur_len;
    if (active && cur && (cur_len != 6'd0)) begin
      cand_valid = 1'b1;
    end else if (active && !cur && last_active) begin
      cand_valid = 1'b1;
      cand_start = (cur_len == 6'd0) ? cnt : cur_start;
      cand_len   = cur_len + 6'd1;
    end
  end

  assign take = cand_valid && (cand_len >= request_size) &&
                (!found ||
                 ((fit_mode == bpaf_pkg::MODE_BEST) && (cand_len < best_len)) ||
                 ((fit_mode == bpaf_pkg::MODE_WORST) && (cand_len > best_len)));

  always_ff @(posedge clk) begin
    if (rst) begin
      shreg     <= '0;
      cnt       <= '0;
      cur_len   <= '0;
      found     <= 1'b0;
      free_cnt  <= '0;
      alloc_hit <= 1'b0;
      test_bit  <= 1'b0;
    end else if (ctrl.init) begin
      cnt       <= '0;
      cur_len   <= '0;
      found     <= 1'b0;
      free_cnt  <= '0;
      alloc_hit <= 1'b0;
      test_bit  <= 1'b0;
    end else if (ctrl.step) begin
      shreg <= {bit_new, shreg[MAP_BITS-1:1]};
      cnt   <= (cnt == IDXW'(MAP_BITS - 1)) ? '0 : cnt + IDXW'(1);
      if (active && !cur) begin
        cur_len <= cur_len + 6'd1;
        if (cur_len == 6'd0) cur_start <= cnt;
      end else begin
        cur_len <= '0;
      end
      if (take) begin
        found      <= 1'b1;
        best_start <= cand_start;
        best_len   <= cand_len;
      end
      if (active && !bit_new) free_cnt <= free_cnt + 6'd1;
      if ((kind == bpaf_pkg::KIND_FIND) && active && !cur && !alloc_hit) begin
        alloc_hit <= 1'b1;
        alloc_pos <= cnt;
      end
      if (idx_here) test_bit <= cur;
    end
  end

  always_comb begin
    res.last       = ctrl.step && (cnt == IDXW'(MAP_BITS - 1));
    res.status     = bpaf_pkg::STATUS_OK;
    res.position   = '0;
    res.bit_set    = 1'b0;
    res.free_count = free_cnt;
    case (kind)
      bpaf_pkg::KIND_MARK, bpaf_pkg::KIND_CLEAR: begin
        if (!idx_ok) res.status = bpaf_pkg::STATUS_BAD_INDEX;
      end
      bpaf_pkg::KIND_TEST: begin
        if (!idx_ok) begin
          res.status = bpaf_pkg::STATUS_BAD_INDEX;
        end else begin
          res.bit_set = test_bit;
        end
      end
      bpaf_pkg::KIND_FIND: begin
        if (alloc_hit) begin
          res.position = 5'(alloc_pos);
        end else begin
          res.status = bpaf_pkg::STATUS_NO_SPACE;
        end
      end
      bpaf_pkg::KIND_RUN: begin
        if (free_cnt < request_size) begin
          res.status = bpaf_pkg::STATUS_NO_SPACE;
        end else if (request_size == 6'd0) begin
          res.position = '0;
        end else if (found) begin
          res.position = 5'(best_start);
        end else begin
          res.status = bpaf_pkg::STATUS_NO_SPACE;
        end
      end
      default: res.status = bpaf_pkg::STATUS_OK;
    endcase
  end

endmodule
